/* hdl/sfc_pkg.sv */
// Shared types and constants of the serial frame checker.
package sfc_pkg;

  localparam int unsigned MAX_PAYLOAD_BYTES = 1024;
  localparam int unsigned HEADER_BYTES      = 4;
  localparam int unsigned FRAME_OVERHEAD    = HEADER_BYTES + 2;
  localparam int unsigned POS_RAW           = MAX_PAYLOAD_BYTES + FRAME_OVERHEAD + 1;
  localparam int unsigned POS_SAT_INT       = (POS_RAW > 2047) ? 2047 : POS_RAW;

  localparam int unsigned POS_W  = 11;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned ADDR_W = 4;

  localparam logic [POS_W-1:0] POS_SAT    = POS_W'(POS_SAT_INT);
  localparam logic [7:0]       START_MARK = 8'hAA;

  localparam logic [7:0] END_MARKER_RST   = 8'h55;
  localparam logic [7:0] TYPE_FLOOR_RST   = 8'h00;
  localparam logic [7:0] TYPE_CEILING_RST = 8'hFF;

  typedef enum logic [1:0] {
    REG_END_MARKER   = 2'd0,
    REG_TYPE_FLOOR   = 2'd1,
    REG_TYPE_CEILING = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    VERDICT_OK         = 3'd0,
    VERDICT_SHORT      = 3'd1,
    VERDICT_BAD_START  = 3'd2,
    VERDICT_BAD_END    = 3'd3,
    VERDICT_LENGTH     = 3'd4,
    VERDICT_CHECKSUM   = 3'd5,
    VERDICT_BAD_TYPE   = 3'd6
  } verdict_e;

  typedef struct packed {
    logic [7:0] end_marker;
    logic [7:0] type_floor;
    logic [7:0] type_ceiling;
  } sfc_cfg_t;

  typedef struct packed {
    logic [7:0]       byte_echo;
    logic [POS_W-1:0] byte_position;
    logic             frame_done;
    logic [2:0]       verdict;
    logic [7:0]       frame_type;
    logic [LEN_W-1:0] payload_length;
  } sfc_res_t;

endpackage

/* hdl/sfc_in_if.sv */
// Input byte channel of the serial frame checker.
interface sfc_in_if import sfc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_last;

  modport source (output valid, output rx_byte, output frame_last, input ready);
  modport sink (input valid, input rx_byte, input frame_last, output ready);
endinterface

/* hdl/sfc_out_if.sv */
// Result channel of the serial frame checker.
interface sfc_out_if import sfc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [7:0]       byte_echo;
  logic [POS_W-1:0] byte_position;
  logic             frame_done;
  logic [2:0]       verdict;
  logic [7:0]       frame_type;
  logic [LEN_W-1:0] payload_length;

  modport source (output valid, output byte_echo, output byte_position, output frame_done,
                  output verdict, output frame_type, output payload_length, input ready);
  modport sink (input valid, input byte_echo, input byte_position, input frame_done,
                input verdict, input frame_type, input payload_length, output ready);
endinterface

/* hdl/sfc_cfg.sv */
// APB configuration registers of the serial frame checker.
module sfc_cfg import sfc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output sfc_cfg_t          cfg_o
);

  sfc_cfg_t cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_END_MARKER:   cfg_d.end_marker   = pwdata[7:0];
        REG_TYPE_FLOOR:   cfg_d.type_floor   = pwdata[7:0];
        REG_TYPE_CEILING: cfg_d.type_ceiling = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_END_MARKER:   prdata = {24'd0, cfg_q.end_marker};
      REG_TYPE_FLOOR:   prdata = {24'd0, cfg_q.type_floor};
      REG_TYPE_CEILING: prdata = {24'd0, cfg_q.type_ceiling};
      default:          prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.end_marker   <= END_MARKER_RST;
      cfg_q.type_floor   <= TYPE_FLOOR_RST;
      cfg_q.type_ceiling <= TYPE_CEILING_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* hdl/sfc_core.sv */
// Frame state and per-byte verdict logic of the serial frame checker.
module sfc_core import sfc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       beat_i,
  input  logic [7:0] rx_byte_i,
  input  logic       frame_last_i,
  input  sfc_cfg_t   cfg_i,
  output sfc_res_t   res_o
);

  logic [POS_W-1:0] count_q, count_d;
  logic [7:0]       xor_q, xor_d;
  logic [7:0]       prev_q, prev_d;
  logic [7:0]       start_q, start_d;
  logic [7:0]       type_q, type_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W:0]   total_got;
  logic [LEN_W:0]   total_want;
  verdict_e         verdict;

  always_comb begin
    start_d = start_q;
    type_d  = type_q;
    len_d   = len_q;
    unique case (count_q)
      POS_W'(0): start_d = rx_byte_i;
      POS_W'(1): type_d  = rx_byte_i;
      POS_W'(2): len_d   = {len_q[15:8], rx_byte_i};
      POS_W'(3): len_d   = {rx_byte_i, len_q[7:0]};
      default: ;
    endcase
  end

  assign total_got  = (LEN_W+1)'(count_q) + (LEN_W+1)'(1);
  assign total_want = (LEN_W+1)'(FRAME_OVERHEAD) + {1'b0, len_d};

  always_comb begin
    priority if (count_q < POS_W'(FRAME_OVERHEAD - 1)) begin
      verdict = VERDICT_SHORT;
    end else if (start_d != START_MARK) begin
      verdict = VERDICT_BAD_START;
    end else if (rx_byte_i != cfg_i.end_marker) begin
      verdict = VERDICT_BAD_END;
    end else if (count_q >= POS_SAT || total_got != total_want) begin
      verdict = VERDICT_LENGTH;
    end else if (xor_q != 8'd0) begin
      verdict = VERDICT_CHECKSUM;
    end else if (type_d <= cfg_i.type_floor || type_d >= cfg_i.type_ceiling) begin
      verdict = VERDICT_BAD_TYPE;
    end else begin
      verdict = VERDICT_OK;
    end
  end

  always_comb begin
    res_o.byte_echo      = rx_byte_i;
    res_o.byte_position  = count_q;
    res_o.frame_done     = frame_last_i;
    res_o.verdict        = frame_last_i ? verdict : VERDICT_OK;
    res_o.frame_type     = frame_last_i ? type_d : 8'd0;
    res_o.payload_length = frame_last_i ? len_d : LEN_W'(0);
  end

  always_comb begin
    count_d = count_q;
    xor_d   = xor_q;
    prev_d  = prev_q;
    if (beat_i) begin
      if (frame_last_i) begin
        count_d = '0;
        xor_d   = '0;
        prev_d  = '0;
      end else begin
        if (count_q < POS_SAT) begin
          count_d = count_q + POS_W'(1);
        end
        xor_d  = xor_q ^ rx_byte_i;
        prev_d = rx_byte_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      xor_q   <= '0;
      prev_q  <= '0;
      start_q <= '0;
      type_q  <= '0;
      len_q   <= '0;
    end else begin
      count_q <= count_d;
      xor_q   <= xor_d;
      prev_q  <= prev_d;
      if (beat_i) begin
        start_q <= frame_last_i ? 8'd0 : start_d;
        type_q  <= frame_last_i ? 8'd0 : type_d;
        len_q   <= frame_last_i ? LEN_W'(0) : len_d;
      end
    end
  end

endmodule

/* hdl/sfc_outq.sv */
// Two-entry result register queue of the serial frame checker.
module sfc_outq import sfc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  sfc_res_t data_i,
  output logic     full_o,
  output logic     valid_o,
  input  logic     pop_ready_i,
  output sfc_res_t data_o
);

  sfc_res_t   slot_q [2];
  logic       rd_q, rd_d;
  logic       wr_q, wr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = slot_q[rd_q];
  assign pop     = valid_o & pop_ready_i;

  always_comb begin
    rd_d  = pop ? ~rd_q : rd_q;
    wr_d  = push_i ? ~wr_q : wr_q;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= data_i;
    end
  end

endmodule

/* hdl/serial_frame_checker_xor.sv */
// Top level of the serial frame checker with XOR checksum.
//
//   channel  direction  content
//   rx_i     in         rx_byte, frame_last
//   res_o    out        byte_echo, byte_position, frame_done, verdict, frame_type,
//                       payload_length
//   apb      in         end_marker, type_floor, type_ceiling at 0x0, 0x4, 0x8
//
// One byte is taken per cycle unless the queue is full; each result is queued.
// The verdict is formed in the same cycle the byte is taken, from the frame state.
// Reset clears the frame state and loads the register defaults.
// A two-entry result queue keeps input open while one result waits; rx_i.ready
// drops only when both entries are held.
module serial_frame_checker_xor import sfc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  sfc_in_if.sink            rx_i,
  sfc_out_if.source         res_o
);

  sfc_cfg_t cfg;
  sfc_res_t res_new;
  sfc_res_t res_head;
  logic     q_full;
  logic     beat;

  assign rx_i.ready = ~q_full;
  assign beat       = rx_i.valid & ~q_full;

  sfc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sfc_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_i       (beat),
    .rx_byte_i    (rx_i.rx_byte),
    .frame_last_i (rx_i.frame_last),
    .cfg_i        (cfg),
    .res_o        (res_new)
  );

  sfc_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (beat),
    .data_i      (res_new),
    .full_o      (q_full),
    .valid_o     (res_o.valid),
    .pop_ready_i (res_o.ready),
    .data_o      (res_head)
  );

  assign res_o.byte_echo      = res_head.byte_echo;
  assign res_o.byte_position  = res_head.byte_position;
  assign res_o.frame_done     = res_head.frame_done;
  assign res_o.verdict        = res_head.verdict;
  assign res_o.frame_type     = res_head.frame_type;
  assign res_o.payload_length = res_head.payload_length;

endmodule
